@@ rtl/core/pmht_pkg.sv @@
// ----------------------------------------------------------------------------
// pmht_pkg
// Types and constants for the prime modulus hash table.
// ----------------------------------------------------------------------------
package pmht_pkg;

    localparam int TableDepth = 64;
    localparam int SlotW      = $clog2(TableDepth);
    localparam int CountW     = $clog2(TableDepth + 1);
    localparam int KeyW       = 31;
    localparam int SizeW      = 7;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;
    localparam logic [1:0] KIND_COUNT  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOTFND  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOCLR   = 2'd3;

    typedef struct packed {
        logic [1:0]      kind;
        logic [KeyW-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        status;
        logic [5:0]        slot;
        logic [6:0]        empty_count;
        logic [5:0]        modulus;
        logic              last;
    } t_out_word;

    // Largest prime strictly below n (n <= 64), zero if none. Constant table.
    function automatic logic [5:0] prime_below(input logic [6:0] n);
        logic [5:0] p;
        p = 6'd0;
        if (n > 7'd61) p = 6'd61;
        else if (n > 7'd59) p = 6'd59;
        else if (n > 7'd53) p = 6'd53;
        else if (n > 7'd47) p = 6'd47;
        else if (n > 7'd43) p = 6'd43;
        else if (n > 7'd41) p = 6'd41;
        else if (n > 7'd37) p = 6'd37;
        else if (n > 7'd31) p = 6'd31;
        else if (n > 7'd29) p = 6'd29;
        else if (n > 7'd23) p = 6'd23;
        else if (n > 7'd19) p = 6'd19;
        else if (n > 7'd17) p = 6'd17;
        else if (n > 7'd13) p = 6'd13;
        else if (n > 7'd11) p = 6'd11;
        else if (n > 7'd7)  p = 6'd7;
        else if (n > 7'd5)  p = 6'd5;
        else if (n > 7'd3)  p = 6'd3;
        else if (n > 7'd2)  p = 6'd2;
        return p;
    endfunction

endpackage

@@ rtl/core/prime_modulus_hash_table_core.sv @@
// ----------------------------------------------------------------------------
// prime_modulus_hash_table_core
// Open-addressing key table, linear probing, prime hash modulus.
// ----------------------------------------------------------------------------
// channel | dir | handshake           | word
// in      | in  | i_valid / o_stall   | t_in_word  (kind, key)
// out     | out | o_valid / i_stall   | t_out_word (status, slot, count, modulus, last)
// cfg     | in  | i_cfg_we            | table_size, 7 bits
//
// Clear: all occupancy bits drop at once. Insert: the remainder unit runs,
// then each probe reads a slot and checks it. Search: every used slot is
// read and checked in turn. Count and rejected words are emitted directly.
// Each read goes through the single-port key memory (registered read). One
// word is processed at a time; a finished word waits in the output register
// while i_stall is high and the next word may be taken and prepared meanwhile.
// Reset leaves the memory unknown; an occupancy bit per slot marks it empty.
// ----------------------------------------------------------------------------
module prime_modulus_hash_table_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  pmht_pkg::t_in_word          i_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output pmht_pkg::t_out_word         o_data,
    input  logic                        i_cfg_we,
    input  logic [pmht_pkg::SizeW-1:0]  i_cfg_wdata
);
    import pmht_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_PRD   = 4'd3;
    localparam logic [3:0] S_PCHK  = 4'd4;
    localparam logic [3:0] S_SRD   = 4'd5;
    localparam logic [3:0] S_SCHK  = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_WAIT  = 4'd8;

    logic [KeyW-1:0]   r_mem [TableDepth];
    logic [KeyW-1:0]   r_rdata;
    logic [TableDepth-1:0] r_occ;

    logic [3:0]        r_state;
    logic [SizeW-1:0]  r_size;
    logic [SizeW-1:0]  r_used;
    logic [5:0]        r_prime;
    logic [CountW-1:0] r_empty;
    logic [KeyW-1:0]   r_key;
    logic [SlotW-1:0]  r_pos;
    logic [SizeW-1:0]  r_iter;
    logic              r_hit;
    logic [SlotW-1:0]  r_hslot;
    logic              r_ovalid;
    t_out_word         r_odata;
    t_out_word         r_res;
    logic              w_mdone;
    logic [5:0]        w_rem;
    logic              w_take;
    logic              w_oready;
    logic              w_match;
    logic              w_push;
    logic [SlotW-1:0]  w_nxt;
    logic [SizeW-1:0]  w_clamp;

    assign w_take   = i_valid && !o_stall;
    assign w_oready = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_data   = r_odata;
    assign w_match  = r_occ[r_pos] && (r_rdata == r_key);
    assign w_clamp  = (r_size > SizeW'(TableDepth)) ? SizeW'(TableDepth) : r_size;
    // next probe position, wrapping at the used slot count
    assign w_nxt    = ({1'b0, r_pos} + 7'd1 >= r_used) ? '0 : r_pos + SlotW'(1);
    // a word enters the output register
    assign w_push   = w_oready && ((r_state == S_EMIT) || (r_state == S_WAIT) ||
                                   (r_state == S_SCHK && r_hit && w_match));

    pmht_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_take && i_data.kind == KIND_INSERT),
        .i_key   (i_data.key),
        .i_div   (r_prime),
        .o_done  (w_mdone),
        .o_rem   (w_rem)
    );

    // key memory: one port, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_PCHK && !r_occ[r_pos] && r_iter != '0)
            r_mem[r_pos] <= r_key;
        r_rdata <= r_mem[r_pos];
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_size <= 7'd64;
        else if (i_cfg_we) r_size <= i_cfg_wdata;
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_push) r_ovalid <= 1'b1;
        else if (!i_stall) r_ovalid <= 1'b0;
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_occ    <= '0;
            r_used   <= SizeW'(TableDepth);
            r_prime  <= '0;
            r_empty  <= CountW'(TableDepth);
            r_pos    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_key   <= i_data.key;
                        r_hit   <= 1'b0;
                        r_pos   <= '0;
                        r_iter  <= '0;
                        unique case (i_data.kind)
                            KIND_CLEAR: r_state <= S_CLR;
                            KIND_INSERT: begin
                                if (r_prime == '0) begin
                                    r_res   <= '{ST_NOCLR, 6'd0, r_empty, r_prime, 1'b1};
                                    r_state <= S_EMIT;
                                end else if (i_data.key == '0) begin
                                    r_res   <= '{ST_NOTFND, 6'd0, r_empty, r_prime, 1'b1};
                                    r_state <= S_EMIT;
                                end else r_state <= S_MOD;
                            end
                            KIND_SEARCH: begin
                                if (i_data.key == '0 || r_used == '0) begin
                                    r_res   <= '{ST_NOTFND, 6'd0, r_empty, r_prime, 1'b1};
                                    r_state <= S_EMIT;
                                end else r_state <= S_SRD;
                            end
                            default: begin
                                r_res   <= '{ST_OK, 6'd0, r_empty, r_prime, 1'b1};
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_occ   <= '0;
                    r_used  <= w_clamp;
                    r_prime <= prime_below(w_clamp);
                    r_empty <= CountW'(w_clamp);
                    r_res   <= '{ST_OK, 6'd0, CountW'(w_clamp), prime_below(w_clamp), 1'b1};
                    r_state <= S_EMIT;
                end
                S_MOD: begin
                    if (w_mdone) begin
                        r_pos   <= ({1'b0, w_rem} >= r_used) ? '0 : w_rem;
                        r_iter  <= r_used;
                        r_state <= S_PRD;
                    end
                end
                S_PRD: r_state <= S_PCHK;
                S_PCHK: begin
                    if (r_iter == '0) begin
                        r_res   <= '{ST_FULL, 6'd0, r_empty, r_prime, 1'b1};
                        r_state <= S_EMIT;
                    end else if (!r_occ[r_pos]) begin
                        r_occ[r_pos] <= 1'b1;
                        r_res   <= '{ST_OK, 6'(r_pos), r_empty - CountW'(1), r_prime, 1'b1};
                        r_empty <= r_empty - CountW'(1);
                        r_state <= S_EMIT;
                    end else begin
                        r_iter  <= r_iter - SizeW'(1);
                        r_pos   <= w_nxt;
                        r_state <= S_PRD;
                    end
                end
                S_SRD: r_state <= S_SCHK;
                S_SCHK: begin
                    // a new hit releases the pending one, which is then not the last;
                    // it waits here while the output register is full
                    if (!(w_match && r_hit && !w_oready)) begin
                        if (w_match) begin
                            if (r_hit)
                                r_odata <= '{ST_OK, 6'(r_hslot), r_empty, r_prime, 1'b0};
                            r_hit   <= 1'b1;
                            r_hslot <= r_pos;
                        end
                        if ({1'b0, r_pos} + 7'd1 >= r_used) begin
                            r_state <= S_WAIT;
                        end else begin
                            r_pos   <= r_pos + SlotW'(1);
                            r_state <= S_SRD;
                        end
                    end
                end
                S_WAIT: begin
                    if (w_oready) begin
                        if (r_hit)
                            r_odata <= '{ST_OK, 6'(r_hslot), r_empty, r_prime, 1'b1};
                        else
                            r_odata <= '{ST_NOTFND, 6'd0, r_empty, r_prime, 1'b1};
                        r_hit    <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (w_oready) begin
                        r_odata  <= r_res;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("busy but not stalling");
    a_empty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty <= CountW'(r_used)) else $error("empty count above used slots");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> (r_ovalid && $stable(r_odata)))
        else $error("output word changed while stalled");
`endif
endmodule

@@ rtl/core/pmht_mod.sv @@
// ----------------------------------------------------------------------------
// pmht_mod
// Bit-serial restoring remainder of a 31-bit key by a 6-bit modulus.
// ----------------------------------------------------------------------------
module pmht_mod (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [pmht_pkg::KeyW-1:0] i_key,
    input  logic [5:0]             i_div,
    output logic                   o_done,
    output logic [5:0]             o_rem
);
    import pmht_pkg::*;

    logic              r_busy;
    logic [4:0]        r_cnt;
    logic [KeyW-1:0]   r_key;
    logic [5:0]        r_rem;
    logic [5:0]        r_div;
    logic              r_done;
    logic [6:0]        w_sh;

    // shift in one key bit, subtract when possible
    assign w_sh = {r_rem, r_key[KeyW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(KeyW - 1);
                r_key  <= i_key;
                r_div  <= i_div;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_key <= {r_key[KeyW-2:0], 1'b0};
                r_rem <= (w_sh >= {1'b0, r_div}) ? 6'(w_sh - {1'b0, r_div}) : 6'(w_sh);
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule
